### design/ampb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ampb_pkg
// Shared types, constants and helpers of the min/max peak binner.
// ----------------------------------------------------------------------------
package ampb_pkg;

  // default sizes handed to the top level
  localparam int unsigned CoarseRatioDef  = 64;
  localparam int unsigned BinIndexBitsDef = 24;

  // fixed field widths
  localparam int unsigned SampleW    = 16;
  localparam int unsigned BinNumberW = 24;
  localparam int unsigned FramesW    = 11;
  localparam int unsigned ChanW      = 2;
  localparam int unsigned FrameCntW  = 10;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 11;

  // bin length limits
  localparam logic [FramesW-1:0] MinBinLen = 11'd1;
  localparam logic [FramesW-1:0] MaxBinLen = 11'd1024;

  // register reset values
  localparam logic [FramesW-1:0] FramesPerBinRst = 11'd96;
  localparam logic [ChanW-1:0]   ChannelCountRst = 2'd2;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // empty accumulator markers
  localparam logic signed [SampleW-1:0] EmptyMax = 16'sh8000;
  localparam logic signed [SampleW-1:0] EmptyMin = 16'sh7fff;

  typedef enum logic {
    CmdFrame = 1'b0,
    CmdFlush = 1'b1
  } cmd_e;

  typedef enum logic {
    LevelFine   = 1'b0,
    LevelCoarse = 1'b1
  } level_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegFramesPerBin = 1'b0,
    RegChannelCount = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    level_e                    level;
    logic [BinNumberW-1:0]     bin_number;
    logic signed [SampleW-1:0] max_first;
    logic signed [SampleW-1:0] min_first;
    logic signed [SampleW-1:0] max_second;
    logic signed [SampleW-1:0] min_second;
    logic                      last;
  } result_t;

  // results of one item: fine result first, coarse result second
  typedef struct packed {
    logic [1:0] count;
    result_t    fine;
    result_t    coarse;
  } push_t;

  // build a result, masking the second channel when mono
  function automatic result_t make_result(
    input level_e                    level,
    input logic [BinNumberW-1:0]     bin_number,
    input logic signed [SampleW-1:0] mx0,
    input logic signed [SampleW-1:0] mn0,
    input logic signed [SampleW-1:0] mx1,
    input logic signed [SampleW-1:0] mn1,
    input logic                      stereo,
    input logic                      last
  );
    result_t r;
    r.level      = level;
    r.bin_number = bin_number;
    r.max_first  = mx0;
    r.min_first  = mn0;
    r.max_second = stereo ? mx1 : EmptyMax;
    r.min_second = stereo ? mn1 : EmptyMin;
    r.last       = last;
    return r;
  endfunction

endpackage
`default_nettype wire

### design/audio_min_max_peak_binner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_min_max_peak_binner
// Min/max peak binner for one- or two-channel 16-bit audio frames, with fine
// and coarse bins and a flush command.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        to block   in_valid_i/in_ready_o   cmd, sample_first, sample_second
//  out       from block out_valid_o/out_ready_i level, bin_number, peaks, last
//  cfg       to block   cfg_we_i                cfg_idx_i, cfg_data_i
//
//  One item per cycle while the queue has room; items are registered, then
//  their results are written into the four-entry result queue. A flush or a
//  frame closing a coarse bin gives two results, which leave one at a time.
//  Input stalls while an item is held and the queue has fewer than two free
//  entries. Reset empties all accumulators and counters at once.
// ----------------------------------------------------------------------------
module audio_min_max_peak_binner #(
  parameter int unsigned CoarseRatio  = ampb_pkg::CoarseRatioDef,
  parameter int unsigned BinIndexBits = ampb_pkg::BinIndexBitsDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [ampb_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  wire logic [ampb_pkg::CfgDataW-1:0]          cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   cmd_i,
  input  wire logic signed [ampb_pkg::SampleW-1:0]    sample_first_i,
  input  wire logic signed [ampb_pkg::SampleW-1:0]    sample_second_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic                                        level_o,
  output logic [ampb_pkg::BinNumberW-1:0]             bin_number_o,
  output logic signed [ampb_pkg::SampleW-1:0]         peak_max_first_o,
  output logic signed [ampb_pkg::SampleW-1:0]         peak_min_first_o,
  output logic signed [ampb_pkg::SampleW-1:0]         peak_max_second_o,
  output logic signed [ampb_pkg::SampleW-1:0]         peak_min_second_o,
  output logic                                        last_of_run_o
);

  ampb_pkg::push_t   push;
  ampb_pkg::result_t res;
  logic              push_ok;

  // binning core
  ampb_core #(
    .CoarseRatio  (CoarseRatio),
    .BinIndexBits (BinIndexBits)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .push_ok_i       (push_ok),
    .push_o          (push)
  );

  // result queue
  ampb_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ok_o   (push_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  // result fields to ports
  assign level_o           = res.level;
  assign bin_number_o      = res.bin_number;
  assign peak_max_first_o  = res.max_first;
  assign peak_min_first_o  = res.min_first;
  assign peak_max_second_o = res.max_second;
  assign peak_min_second_o = res.min_second;
  assign last_of_run_o     = res.last;

endmodule
`default_nettype wire

### design/ampb_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ampb_core
// Input register, configuration registers, peak accumulators and bin
// counters. Produces up to two results per item toward the result queue.
// ----------------------------------------------------------------------------
module ampb_core #(
  parameter int unsigned CoarseRatio  = ampb_pkg::CoarseRatioDef,
  parameter int unsigned BinIndexBits = ampb_pkg::BinIndexBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [ampb_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [ampb_pkg::CfgDataW-1:0]        cfg_data_i,
  // input items
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 cmd_i,
  input  wire logic signed [ampb_pkg::SampleW-1:0]  sample_first_i,
  input  wire logic signed [ampb_pkg::SampleW-1:0]  sample_second_i,
  // results toward the queue
  input  wire logic                                 push_ok_i,
  output ampb_pkg::push_t                           push_o
);

  localparam int unsigned CntW = $clog2(CoarseRatio);

  // configuration registers
  logic [ampb_pkg::FramesW-1:0] frames_per_bin_q;
  logic [ampb_pkg::ChanW-1:0]   channel_count_q;

  // input register
  logic                                stg_valid_q, stg_valid_d;
  ampb_pkg::cmd_e                      stg_cmd_q;
  logic signed [ampb_pkg::SampleW-1:0] stg_s0_q, stg_s1_q;

  // accumulators and counters
  logic signed [ampb_pkg::SampleW-1:0] fine_max_q[2], fine_min_q[2];
  logic signed [ampb_pkg::SampleW-1:0] coarse_max_q[2], coarse_min_q[2];
  logic [ampb_pkg::FrameCntW-1:0]      frame_in_bin_q;
  logic [CntW-1:0]                     bin_in_coarse_q;
  logic [BinIndexBits-1:0]             fine_idx_q, coarse_idx_q;

  logic signed [ampb_pkg::SampleW-1:0] fine_max_upd[2], fine_min_upd[2];
  logic signed [ampb_pkg::SampleW-1:0] coarse_max_upd[2], coarse_min_upd[2];
  logic signed [ampb_pkg::SampleW-1:0] smp[2];

  logic                          advance, is_frame, stereo;
  logic [ampb_pkg::FramesW-1:0]  bin_len, frame_inc;
  logic [CntW:0]                 bic_inc;
  logic                          fine_close, coarse_close, fine_emit, coarse_emit;
  logic [BinIndexBits+ampb_pkg::BinNumberW-1:0] fine_idx_wide, coarse_idx_wide;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_per_bin_q <= ampb_pkg::FramesPerBinRst;
      channel_count_q  <= ampb_pkg::ChannelCountRst;
    end else if (cfg_we_i) begin
      unique case (ampb_pkg::cfg_reg_e'(cfg_idx_i))
        ampb_pkg::RegFramesPerBin: frames_per_bin_q <= cfg_data_i;
        ampb_pkg::RegChannelCount: channel_count_q  <= cfg_data_i[ampb_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // input register handshake
  assign advance     = stg_valid_q && push_ok_i;
  assign in_ready_o  = !stg_valid_q || push_ok_i;
  assign stg_valid_d = (in_valid_i && in_ready_o) || (stg_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_cmd_q <= ampb_pkg::cmd_e'(cmd_i);
      stg_s0_q  <= sample_first_i;
      stg_s1_q  <= sample_second_i;
    end
  end

  // peak update for the registered frame
  assign is_frame = (stg_cmd_q == ampb_pkg::CmdFrame);
  assign stereo   = channel_count_q[1];
  assign smp[0]   = stg_s0_q;
  assign smp[1]   = stg_s1_q;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      fine_max_upd[c]   = fine_max_q[c];
      fine_min_upd[c]   = fine_min_q[c];
      coarse_max_upd[c] = coarse_max_q[c];
      coarse_min_upd[c] = coarse_min_q[c];
      if (is_frame && (c == 0 || stereo)) begin
        if (smp[c] > fine_max_q[c])   fine_max_upd[c]   = smp[c];
        if (smp[c] < fine_min_q[c])   fine_min_upd[c]   = smp[c];
        if (smp[c] > coarse_max_q[c]) coarse_max_upd[c] = smp[c];
        if (smp[c] < coarse_min_q[c]) coarse_min_upd[c] = smp[c];
      end
    end
  end

  // bin length clamp and bin closing
  always_comb begin
    priority if (frames_per_bin_q == '0) begin
      bin_len = ampb_pkg::MinBinLen;
    end else if (frames_per_bin_q > ampb_pkg::MaxBinLen) begin
      bin_len = ampb_pkg::MaxBinLen;
    end else begin
      bin_len = frames_per_bin_q;
    end
  end

  assign frame_inc    = {1'b0, frame_in_bin_q} + ampb_pkg::FramesW'(1);
  assign bic_inc      = {1'b0, bin_in_coarse_q} + (CntW+1)'(1);
  assign fine_close   = is_frame && (frame_inc >= bin_len);
  assign coarse_close = fine_close && (bic_inc >= (CntW+1)'(CoarseRatio));
  assign fine_emit    = !is_frame || fine_close;
  assign coarse_emit  = !is_frame || coarse_close;

  // results, bin numbers cut or extended to the port width
  assign fine_idx_wide   = {ampb_pkg::BinNumberW'(0), fine_idx_q};
  assign coarse_idx_wide = {ampb_pkg::BinNumberW'(0), coarse_idx_q};

  always_comb begin
    push_o.count = advance ? ({1'b0, fine_emit} + {1'b0, coarse_emit}) : 2'd0;
    push_o.fine  = ampb_pkg::make_result(ampb_pkg::LevelFine,
        fine_idx_wide[ampb_pkg::BinNumberW-1:0],
        fine_max_upd[0], fine_min_upd[0], fine_max_upd[1], fine_min_upd[1],
        stereo, !coarse_emit);
    push_o.coarse = ampb_pkg::make_result(ampb_pkg::LevelCoarse,
        coarse_idx_wide[ampb_pkg::BinNumberW-1:0],
        coarse_max_upd[0], coarse_min_upd[0], coarse_max_upd[1], coarse_min_upd[1],
        stereo, 1'b1);
  end

  // accumulator and counter state, touched only by frames
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        fine_max_q[c]   <= ampb_pkg::EmptyMax;
        fine_min_q[c]   <= ampb_pkg::EmptyMin;
        coarse_max_q[c] <= ampb_pkg::EmptyMax;
        coarse_min_q[c] <= ampb_pkg::EmptyMin;
      end
      frame_in_bin_q  <= '0;
      bin_in_coarse_q <= '0;
      fine_idx_q      <= '0;
      coarse_idx_q    <= '0;
    end else if (advance && is_frame) begin
      for (int c = 0; c < 2; c++) begin
        fine_max_q[c]   <= fine_close   ? ampb_pkg::EmptyMax : fine_max_upd[c];
        fine_min_q[c]   <= fine_close   ? ampb_pkg::EmptyMin : fine_min_upd[c];
        coarse_max_q[c] <= coarse_close ? ampb_pkg::EmptyMax : coarse_max_upd[c];
        coarse_min_q[c] <= coarse_close ? ampb_pkg::EmptyMin : coarse_min_upd[c];
      end
      if (fine_close) begin
        frame_in_bin_q  <= '0;
        fine_idx_q      <= fine_idx_q + BinIndexBits'(1);
        bin_in_coarse_q <= coarse_close ? '0 : bic_inc[CntW-1:0];
        if (coarse_close) begin
          coarse_idx_q <= coarse_idx_q + BinIndexBits'(1);
        end
      end else begin
        frame_in_bin_q <= frame_inc[ampb_pkg::FrameCntW-1:0];
      end
    end
  end

  // a flush always yields both results
  a_flush_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_frame) |-> (push_o.count == 2'd2))
    else $error("flush did not yield two results");

  // coarse bin counter stays inside the ratio
  a_bic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(bin_in_coarse_q) < CoarseRatio))
    else $error("coarse bin counter out of range");

  // fine index advances by one exactly when a fine bin closes
  a_fine_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && fine_close) |=> (fine_idx_q == $past(fine_idx_q) + BinIndexBits'(1)))
    else $error("fine bin index did not advance");

endmodule
`default_nettype wire

### design/ampb_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ampb_result_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ampb_result_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ampb_pkg::push_t push_i,
  output logic                 push_ok_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output ampb_pkg::result_t    out_o
);

  ampb_pkg::result_t                 mem_q[ampb_pkg::FifoDepth];
  logic [ampb_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [ampb_pkg::FifoCntW-1:0]     count_q, count_d;
  logic                              pop;

  // room for a full pair of results, no matter what is taken this cycle
  assign push_ok_o   = count_q <= ampb_pkg::FifoCntW'(ampb_pkg::FifoDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_nx   = wr_ptr_q + ampb_pkg::FifoPtrW'(1);

  assign count_d = count_q + ampb_pkg::FifoCntW'(push_i.count)
                 - ampb_pkg::FifoCntW'(pop);

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.fine;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.coarse;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ampb_pkg::FifoPtrW'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ampb_pkg::FifoPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  // results arrive only when a pair fits
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> push_ok_o)
    else $error("result queue written without room");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min/max peak binner. A short table of directed
// frames, flushes and register writes runs first, then random phases with
// random bin lengths and channel counts. Every accepted item goes through a
// bench-side peak model, and each output transfer is checked field by field
// against the oldest predicted result. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned RandItems    = 1800;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxPrinted   = 40;

  localparam logic signed [ampb_pkg::SampleW-1:0] SampleHi = 16'sh7fff;
  localparam logic signed [ampb_pkg::SampleW-1:0] SampleLo = 16'sh8000;

  typedef enum logic {
    RowItem  = 1'b0,
    RowWrite = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e                           kind;
    ampb_pkg::cmd_e                      cmd;
    logic signed [ampb_pkg::SampleW-1:0] s0;
    logic signed [ampb_pkg::SampleW-1:0] s1;
    ampb_pkg::cfg_reg_e                  reg_idx;
    logic [ampb_pkg::CfgDataW-1:0]       data;
    int                                  n_typed;
    ampb_pkg::result_t                   want_a;
    ampb_pkg::result_t                   want_b;
  } dir_row_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic                                cfg_we_i        = 1'b0;
  logic [ampb_pkg::CfgIdxW-1:0]        cfg_idx_i       = '0;
  logic [ampb_pkg::CfgDataW-1:0]       cfg_data_i      = '0;
  logic                                in_valid_i      = 1'b0;
  logic                                cmd_i           = 1'b0;
  logic signed [ampb_pkg::SampleW-1:0] sample_first_i  = '0;
  logic signed [ampb_pkg::SampleW-1:0] sample_second_i = '0;
  logic                                out_ready_i     = 1'b0;

  logic                                in_ready_o;
  logic                                out_valid_o;
  logic                                level_o;
  logic [ampb_pkg::BinNumberW-1:0]     bin_number_o;
  logic signed [ampb_pkg::SampleW-1:0] peak_max_first_o;
  logic signed [ampb_pkg::SampleW-1:0] peak_min_first_o;
  logic signed [ampb_pkg::SampleW-1:0] peak_max_second_o;
  logic signed [ampb_pkg::SampleW-1:0] peak_min_second_o;
  logic                                last_of_run_o;

  audio_min_max_peak_binner u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .sample_first_i    (sample_first_i),
    .sample_second_i   (sample_second_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .level_o           (level_o),
    .bin_number_o      (bin_number_o),
    .peak_max_first_o  (peak_max_first_o),
    .peak_min_first_o  (peak_min_first_o),
    .peak_max_second_o (peak_max_second_o),
    .peak_min_second_o (peak_min_second_o),
    .last_of_run_o     (last_of_run_o)
  );

  // bench-side copy of the registers and the binning state
  logic [ampb_pkg::CfgDataW-1:0]        model_fpb  = ampb_pkg::FramesPerBinRst;
  logic [ampb_pkg::ChanW-1:0]           model_chan = ampb_pkg::ChannelCountRst;
  logic signed [ampb_pkg::SampleW-1:0]  fine_hi [2]   =
      '{ampb_pkg::EmptyMax, ampb_pkg::EmptyMax};
  logic signed [ampb_pkg::SampleW-1:0]  fine_lo [2]   =
      '{ampb_pkg::EmptyMin, ampb_pkg::EmptyMin};
  logic signed [ampb_pkg::SampleW-1:0]  coarse_hi [2] =
      '{ampb_pkg::EmptyMax, ampb_pkg::EmptyMax};
  logic signed [ampb_pkg::SampleW-1:0]  coarse_lo [2] =
      '{ampb_pkg::EmptyMin, ampb_pkg::EmptyMin};
  int                                   frames_taken   = 0;
  int                                   bins_in_coarse = 0;
  logic [ampb_pkg::BinIndexBitsDef-1:0] fine_idx   = '0;
  logic [ampb_pkg::BinIndexBitsDef-1:0] coarse_idx = '0;

  ampb_pkg::result_t peak_results_due [$];
  int                err_count    = 0;
  int                results_seen = 0;
  int                cycle_count  = 0;
  int                hold_cnt     = 0;
  logic              calm         = 1'b0;
  dir_row_t          dir_table [$];

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h want %0h",
                                results_seen, name, got, want));
    end
  endtask

  // compare each output transfer with the oldest predicted result
  always @(posedge clk_i) begin : result_monitor
    ampb_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (peak_results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none predicted",
                                  results_seen));
      end else begin
        want = peak_results_due.pop_front();
        check_field("level", 32'(level_o), 32'(want.level));
        check_field("bin_number", 32'(bin_number_o), 32'(want.bin_number));
        check_field("peak_max_first", 32'(peak_max_first_o), 32'(want.max_first));
        check_field("peak_min_first", 32'(peak_min_first_o), 32'(want.min_first));
        check_field("peak_max_second", 32'(peak_max_second_o),
                    32'(want.max_second));
        check_field("peak_min_second", 32'(peak_min_second_o),
                    32'(want.min_second));
        check_field("last_of_run", 32'(last_of_run_o), 32'(want.last));
      end
      results_seen++;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // -------------------------------------------------------------- peak model

  // one result, second channel shown as empty when mono
  function automatic ampb_pkg::result_t build_peak_result(
    input ampb_pkg::level_e                     level,
    input logic [ampb_pkg::BinIndexBitsDef-1:0] idx,
    input logic signed [ampb_pkg::SampleW-1:0]  hi0,
    input logic signed [ampb_pkg::SampleW-1:0]  lo0,
    input logic signed [ampb_pkg::SampleW-1:0]  hi1,
    input logic signed [ampb_pkg::SampleW-1:0]  lo1,
    input logic                                 last
  );
    ampb_pkg::result_t r;
    r.level      = level;
    r.bin_number = idx[ampb_pkg::BinNumberW-1:0];
    r.max_first  = hi0;
    r.min_first  = lo0;
    r.max_second = (model_chan >= 2) ? hi1 : ampb_pkg::EmptyMax;
    r.min_second = (model_chan >= 2) ? lo1 : ampb_pkg::EmptyMin;
    r.last       = last;
    return r;
  endfunction

  // advance the binning state by one item and return the results it causes
  task automatic advance_binner(
    input  ampb_pkg::cmd_e                      cmd,
    input  logic signed [ampb_pkg::SampleW-1:0] s0,
    input  logic signed [ampb_pkg::SampleW-1:0] s1,
    output ampb_pkg::result_t                   res_a,
    output ampb_pkg::result_t                   res_b,
    output int                                  n
  );
    int                                  bin_len;
    int                                  chans;
    logic signed [ampb_pkg::SampleW-1:0] s;
    bin_len = (model_fpb == 0) ? 1 :
              (model_fpb > ampb_pkg::MaxBinLen) ? int'(ampb_pkg::MaxBinLen) :
              int'(model_fpb);
    chans   = (model_chan >= 2) ? 2 : 1;
    n       = 0;
    res_a   = '0;
    res_b   = '0;
    if (cmd == ampb_pkg::CmdFlush) begin
      // partial bins reported, nothing changes
      res_a = build_peak_result(ampb_pkg::LevelFine, fine_idx, fine_hi[0], fine_lo[0],
                                fine_hi[1], fine_lo[1], 1'b0);
      res_b = build_peak_result(ampb_pkg::LevelCoarse, coarse_idx, coarse_hi[0],
                                coarse_lo[0], coarse_hi[1], coarse_lo[1], 1'b1);
      n = 2;
    end else begin
      // take the frame into both levels
      for (int c = 0; c < chans; c++) begin
        s = (c == 0) ? s0 : s1;
        if (s > fine_hi[c])   fine_hi[c]   = s;
        if (s < fine_lo[c])   fine_lo[c]   = s;
        if (s > coarse_hi[c]) coarse_hi[c] = s;
        if (s < coarse_lo[c]) coarse_lo[c] = s;
      end
      frames_taken = (frames_taken + 1) & 11'h7ff;
      // fine bin closes, possibly closing the coarse bin too
      if (frames_taken >= bin_len) begin
        res_a = build_peak_result(ampb_pkg::LevelFine, fine_idx, fine_hi[0],
                                  fine_lo[0], fine_hi[1], fine_lo[1], 1'b1);
        n = 1;
        for (int c = 0; c < 2; c++) begin
          fine_hi[c] = ampb_pkg::EmptyMax;
          fine_lo[c] = ampb_pkg::EmptyMin;
        end
        frames_taken = 0;
        fine_idx++;
        bins_in_coarse++;
        if (bins_in_coarse >= ampb_pkg::CoarseRatioDef) begin
          res_a.last = 1'b0;
          res_b = build_peak_result(ampb_pkg::LevelCoarse, coarse_idx, coarse_hi[0],
                                    coarse_lo[0], coarse_hi[1], coarse_lo[1], 1'b1);
          n = 2;
          for (int c = 0; c < 2; c++) begin
            coarse_hi[c] = ampb_pkg::EmptyMax;
            coarse_lo[c] = ampb_pkg::EmptyMin;
          end
          bins_in_coarse = 0;
          coarse_idx++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [ampb_pkg::SampleW-1:0] rand_sample();
    logic [31:0] w;
    int          r;
    w = $urandom();
    r = $urandom_range(0, 9);
    if (r == 0) return SampleHi;
    if (r == 1) return SampleLo;
    if (r < 4) return ampb_pkg::SampleW'($urandom_range(0, 64)) - 16'sd32;
    return w[ampb_pkg::SampleW-1:0];
  endfunction

  function automatic logic [ampb_pkg::CfgDataW-1:0] pick_bin_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ampb_pkg::CfgDataW'($urandom_range(1, 4));
    if (r < 65) return ampb_pkg::CfgDataW'($urandom_range(5, 16));
    if (r < 75) return ampb_pkg::FramesPerBinRst;
    if (r < 82) return '0;
    if (r < 88) return ampb_pkg::MaxBinLen;
    if (r < 94) return ampb_pkg::CfgDataW'($urandom_range(1025, 2047));
    return ampb_pkg::CfgDataW'($urandom_range(17, 300));
  endfunction

  // output side: random stalls, none in calm stretches
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      hold_cnt    <= pick_stall() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // one input transfer, then predict its results
  task automatic transfer_item(
    input ampb_pkg::cmd_e                      cmd,
    input logic signed [ampb_pkg::SampleW-1:0] s0,
    input logic signed [ampb_pkg::SampleW-1:0] s1,
    input int                                  n_typed,
    input ampb_pkg::result_t                   want_a,
    input ampb_pkg::result_t                   want_b
  );
    int                gap;
    int                n;
    ampb_pkg::result_t res_a;
    ampb_pkg::result_t res_b;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    sample_first_i  <= s0;
    sample_second_i <= s1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_binner(cmd, s0, s1, res_a, res_b, n);
    if (n_typed > 0) begin
      res_a = want_a;
      res_b = want_b;
      n     = n_typed;
    end
    if (n > 0) peak_results_due.push_back(res_a);
    if (n > 1) peak_results_due.push_back(res_b);
  endtask

  // wait until every predicted result is out and the pipeline is quiet
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (peak_results_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input ampb_pkg::cfg_reg_e idx,
                           input logic [ampb_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ampb_pkg::RegFramesPerBin) model_fpb = data;
    else model_chan = data[ampb_pkg::ChanW-1:0];
    @(posedge clk_i);
  endtask

  function automatic dir_row_t item_row(input ampb_pkg::cmd_e cmd,
                                        input logic signed [ampb_pkg::SampleW-1:0] s0,
                                        input logic signed [ampb_pkg::SampleW-1:0] s1);
    dir_row_t row;
    row         = '0;
    row.kind    = RowItem;
    row.cmd     = cmd;
    row.s0      = s0;
    row.s1      = s1;
    return row;
  endfunction

  function automatic dir_row_t write_row(input ampb_pkg::cfg_reg_e idx,
                                         input logic [ampb_pkg::CfgDataW-1:0] data);
    dir_row_t row;
    row         = '0;
    row.kind    = RowWrite;
    row.reg_idx = idx;
    row.data    = data;
    return row;
  endfunction

  initial begin : stimulus
    dir_row_t       row;
    int             rand_items;
    int             phase_len;
    int             pick;
    ampb_pkg::cmd_e cmd;

    // directed table: reset state, extremes, mono, odd register values
    row = item_row(ampb_pkg::CmdFlush, '0, '0);
    row.n_typed = 2;
    row.want_a  = {ampb_pkg::LevelFine, 24'd0, ampb_pkg::EmptyMax, ampb_pkg::EmptyMin,
                   ampb_pkg::EmptyMax, ampb_pkg::EmptyMin, 1'b0};
    row.want_b  = {ampb_pkg::LevelCoarse, 24'd0, ampb_pkg::EmptyMax, ampb_pkg::EmptyMin,
                   ampb_pkg::EmptyMax, ampb_pkg::EmptyMin, 1'b1};
    dir_table.push_back(row);
    dir_table.push_back(write_row(ampb_pkg::RegFramesPerBin, ampb_pkg::MinBinLen));
    row = item_row(ampb_pkg::CmdFrame, SampleHi, SampleLo);
    row.n_typed = 1;
    row.want_a  = {ampb_pkg::LevelFine, 24'd0, SampleHi, SampleHi, SampleLo, SampleLo,
                   1'b1};
    dir_table.push_back(row);
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, SampleLo, SampleHi));
    dir_table.push_back(item_row(ampb_pkg::CmdFlush, '0, '0));
    // mono: second channel ignored and reported empty
    dir_table.push_back(write_row(ampb_pkg::RegChannelCount, 11'd1));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'sh1234, SampleHi));
    dir_table.push_back(item_row(ampb_pkg::CmdFlush, '0, '0));
    // channel count zero acts as mono, three as stereo
    dir_table.push_back(write_row(ampb_pkg::RegChannelCount, 11'd0));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, -16'sd1, 16'sd5));
    dir_table.push_back(write_row(ampb_pkg::RegChannelCount, 11'd3));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'sd5, -16'sd1));
    // zero bin length acts as one frame
    dir_table.push_back(write_row(ampb_pkg::RegFramesPerBin, 11'd0));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'sd100, -16'sd100));
    // bin length lowered mid-bin closes on the next frame
    dir_table.push_back(write_row(ampb_pkg::RegFramesPerBin, 11'd4));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'sd1, 16'sd2));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'sd3, 16'sd4));
    dir_table.push_back(write_row(ampb_pkg::RegFramesPerBin, ampb_pkg::MinBinLen));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'sd7, 16'sd8));
    // oversized bin length acts as the maximum
    dir_table.push_back(write_row(ampb_pkg::RegFramesPerBin, 11'd2047));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'shaaaa, 16'sh5555));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, 16'sh5555, 16'shaaaa));
    dir_table.push_back(item_row(ampb_pkg::CmdFlush, '0, '0));
    dir_table.push_back(write_row(ampb_pkg::RegFramesPerBin, ampb_pkg::MaxBinLen));
    dir_table.push_back(write_row(ampb_pkg::RegChannelCount, 11'd2));
    dir_table.push_back(item_row(ampb_pkg::CmdFrame, SampleLo, SampleLo));
    dir_table.push_back(item_row(ampb_pkg::CmdFlush, '0, '0));

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == RowWrite) begin
        settle_block();
        write_reg(dir_table[i].reg_idx, dir_table[i].data);
      end else begin
        transfer_item(dir_table[i].cmd, dir_table[i].s0, dir_table[i].s1,
                      dir_table[i].n_typed, dir_table[i].want_a,
                      dir_table[i].want_b);
      end
    end

    // random phases, new register settings between phases
    rand_items = 0;
    while (rand_items < RandItems) begin
      settle_block();
      pick = $urandom_range(0, 2);
      if (pick != 1) write_reg(ampb_pkg::RegFramesPerBin, pick_bin_len());
      if (pick != 0) write_reg(ampb_pkg::RegChannelCount,
                               ampb_pkg::CfgDataW'($urandom()));
      calm <= ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(40, 160);
      for (int k = 0; k < phase_len; k++) begin
        cmd = ($urandom_range(0, 19) == 0) ? ampb_pkg::CmdFlush : ampb_pkg::CmdFrame;
        transfer_item(cmd, rand_sample(), rand_sample(), 0, '0, '0);
        rand_items++;
      end
    end

    // drain
    settle_block();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
design/ampb_pkg.sv
design/ampb_core.sv
design/ampb_result_fifo.sv
design/audio_min_max_peak_binner.sv
tb/sv/tb_top.sv
